### hw/rtl/sfd_pkg.sv
// Shared constants and types for the sensor frame deframer.
`default_nettype none
package sfd_pkg;

  localparam int unsigned FrameBytes = 20;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned SumLast    = 19;
  localparam logic [7:0]  SyncByte   = 8'h5A;

  // Pending bytes, entry 0 is the oldest
  typedef logic [FrameBytes-1:0][7:0] win_t;

  // Window update requests from the sequencer
  typedef struct packed {
    logic clear;      // empty the window
    logic push;       // append one byte at the fill position
    logic push_full;  // drop oldest and append at the last entry
    logic shift;      // drop oldest
  } win_ctl_t;

  // Checksum unit requests
  typedef struct packed {
    logic start;
    logic step;
  } sum_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/sensor_frame_deframer_unit.sv
// Top level: sequencer for header search, checksum and field decode.
// Takes one serial byte per request and emits one decoded record per good
// 20-byte frame (header 0x5A 0x5A, byte 19 = sum of bytes 0..18 mod 256).
// A byte is accepted in the idle state. The sequencer then drops one stale
// byte per cycle while the window does not start with the header. For a full
// window it runs the checksum through one 8-bit adder, one byte per cycle,
// before it decodes or drops. Short of an output wait, the slowest byte is
// the one that completes a full frame with a bad sum and no header behind it.
// The last byte of a good frame can further wait for the output register.
// The decoded record sits in that output register, so the next byte is taken
// while it waits. In the emit state the sequencer holds off only when a new
// record is ready and the previous one has not yet been taken.
`default_nettype none
module sensor_frame_deframer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_temperature_centi,
  output logic [15:0]             out_humidity_centi,
  output logic [23:0]             out_pressure_centi,
  output logic [3:0]              out_iaq_conf,
  output logic [11:0]             out_iaq_index,
  output logic [31:0]             out_gas_ohms,
  output logic signed [15:0]      out_altitude_m
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StSum  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  sfd_pkg::win_ctl_t            win_ctl;
  sfd_pkg::sum_ctl_t            sum_ctl;
  sfd_pkg::win_t                win;
  logic [sfd_pkg::IdxW-1:0]     fill;
  logic [sfd_pkg::IdxW-1:0]     rd_idx;
  logic [7:0]                   rd_byte;
  logic                         sum_last;
  logic                         sum_match;
  logic                         header;
  logic                         in_acc;
  logic                         load;
  logic                         out_valid_r;
  logic                         out_valid_nxt;

  logic signed [15:0]           temp_r;
  logic [15:0]                  hum_r;
  logic [23:0]                  pres_r;
  logic [3:0]                   acc_r;
  logic [11:0]                  iaq_r;
  logic [31:0]                  gas_r;
  logic signed [15:0]           alt_r;

  sfd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .wr_byte (in_rx_byte),
    .rd_idx  (rd_idx),
    .win     (win),
    .fill    (fill),
    .rd_byte (rd_byte)
  );

  sfd_checksum u_checksum (
    .clk        (clk),
    .ctl        (sum_ctl),
    .rd_byte    (rd_byte),
    .check_byte (win[sfd_pkg::SumLast]),
    .rd_idx     (rd_idx),
    .last       (sum_last),
    .match      (sum_match)
  );

  assign in_stall = (state_r != StIdle);
  assign in_acc   = in_valid && !in_stall;
  assign header   = (win[0] == sfd_pkg::SyncByte) && (win[1] == sfd_pkg::SyncByte);
  assign load     = (state_r == StEmit) && (!out_valid_r || !out_stall);

  // Sequencer: take a byte, drop until header, checksum a full frame, emit
  always_comb begin
    state_nxt = state_r;
    win_ctl   = '0;
    sum_ctl   = '0;
    unique case (state_r)
      StIdle: begin
        if (in_acc) begin
          if (fill == sfd_pkg::IdxW'(sfd_pkg::FrameBytes)) begin
            win_ctl.push_full = 1'b1;
          end else begin
            win_ctl.push = 1'b1;
          end
          state_nxt = StScan;
        end
      end
      StScan: begin
        if (fill < sfd_pkg::IdxW'(2)) begin
          state_nxt = StIdle;
        end else if (!header) begin
          win_ctl.shift = 1'b1;
        end else if (fill < sfd_pkg::IdxW'(sfd_pkg::FrameBytes)) begin
          state_nxt = StIdle;
        end else begin
          sum_ctl.start = 1'b1;
          state_nxt     = StSum;
        end
      end
      StSum: begin
        sum_ctl.step = 1'b1;
        if (sum_last) begin
          if (sum_match) begin
            state_nxt = StEmit;
          end else begin
            win_ctl.shift = 1'b1;
            state_nxt     = StScan;
          end
        end
      end
      StEmit: begin
        if (load) begin
          win_ctl.clear = 1'b1;
          state_nxt     = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Decode the big-endian fields of the frame
  always_ff @(posedge clk) begin
    if (load) begin
      temp_r <= {win[4], win[5]};
      hum_r  <= {win[6], win[7]};
      pres_r <= {win[8], win[9], win[10]};
      acc_r  <= win[11][7:4];
      iaq_r  <= {win[11][3:0], win[12]};
      gas_r  <= {win[13], win[14], win[15], win[16]};
      alt_r  <= {win[17], win[18]};
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = temp_r;
  assign out_humidity_centi    = hum_r;
  assign out_pressure_centi    = pres_r;
  assign out_iaq_conf          = acc_r;
  assign out_iaq_index         = iaq_r;
  assign out_gas_ohms          = gas_r;
  assign out_altitude_m        = alt_r;

endmodule
`default_nettype wire

### hw/rtl/sfd_window.sv
// Pending byte window with fill count and one indexed read port.
`default_nettype none
module sfd_window (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sfd_pkg::win_ctl_t          ctl,
  input  wire logic [7:0]                 wr_byte,
  input  wire logic [sfd_pkg::IdxW-1:0]   rd_idx,
  output sfd_pkg::win_t                   win,
  output logic [sfd_pkg::IdxW-1:0]        fill,
  output logic [7:0]                      rd_byte
);

  sfd_pkg::win_t                   win_r;
  logic [sfd_pkg::IdxW-1:0]        fill_r;
  logic [sfd_pkg::IdxW-1:0]        fill_nxt;

  // Fill count follows the request
  always_comb begin
    fill_nxt = fill_r;
    priority if (ctl.clear) begin
      fill_nxt = '0;
    end else if (ctl.push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (ctl.shift) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Shift out the oldest byte, write the new one, or both into a full window
  always_ff @(posedge clk) begin
    if (ctl.shift || ctl.push_full) begin
      for (int i = 0; i < sfd_pkg::FrameBytes - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
    end
    if (ctl.push_full) begin
      win_r[sfd_pkg::FrameBytes-1] <= wr_byte;
    end else if (ctl.push) begin
      win_r[fill_r] <= wr_byte;
    end
  end

  assign win     = win_r;
  assign fill    = fill_r;
  assign rd_byte = win_r[rd_idx];

endmodule
`default_nettype wire

### hw/rtl/sfd_checksum.sv
// Byte-serial checksum accumulator over the frame body.
`default_nettype none
module sfd_checksum (
  input  wire logic                       clk,
  input  wire sfd_pkg::sum_ctl_t          ctl,
  input  wire logic [7:0]                 rd_byte,
  input  wire logic [7:0]                 check_byte,
  output logic [sfd_pkg::IdxW-1:0]        rd_idx,
  output logic                            last,
  output logic                            match
);

  logic [sfd_pkg::IdxW-1:0] idx_r;
  logic [7:0]               acc_r;
  logic [7:0]               acc_nxt;

  // Add the current byte; the sum wraps modulo 256
  assign acc_nxt = acc_r + rd_byte;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx_r <= '0;
      acc_r <= '0;
    end else if (ctl.step) begin
      idx_r <= idx_r + 1'b1;
      acc_r <= acc_nxt;
    end
  end

  assign rd_idx = idx_r;
  assign last   = (idx_r == sfd_pkg::IdxW'(sfd_pkg::SumLast - 1));
  assign match  = (acc_nxt == check_byte);

endmodule
`default_nettype wire
